### hw/rtl/iaid_pkg.sv
`timescale 1ns / 1ps
// Package for the indexed array with insert and delete.
// Holds the shared widths, operation and status codes and the cell control type.
// Used by iaid_cell and indexed_array_insert_delete.
package iaid_pkg;

  localparam int DATA_W       = 32;
  localparam int FUNC_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 64;
  localparam int CNT_W_DEF    = $clog2(CAPACITY_DEF + 1);

  typedef enum logic [FUNC_W-1:0] {
    OP_REPLACE = 3'd0,
    OP_INSERT  = 3'd1,
    OP_DELETE  = 3'd2,
    OP_SWAP    = 3'd3,
    OP_FIND    = 3'd4,
    OP_READ    = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic rep;
    logic ins;
    logic del;
    logic swp;
  } cell_ctrl_t;

endpackage

### hw/rtl/iaid_cell.sv
`timescale 1ns / 1ps
// One cell of the array row: holds a single word at a fixed position.
// Takes its neighbours' words for shifts; depends on iaid_pkg.
module iaid_cell #(
  parameter int CNT_W    = iaid_pkg::CNT_W_DEF,
  parameter int CELL_IDX = 0
) (
  input  logic                        clk_i,
  input  iaid_pkg::cell_ctrl_t        ctrl_i,
  input  logic [CNT_W-1:0]            a_i,
  input  logic [CNT_W-1:0]            b_i,
  input  logic [CNT_W-1:0]            count_i,
  input  logic [iaid_pkg::DATA_W-1:0] value_i,
  input  logic [iaid_pkg::DATA_W-1:0] word_a_i,
  input  logic [iaid_pkg::DATA_W-1:0] word_b_i,
  input  logic [iaid_pkg::DATA_W-1:0] prev_i,
  input  logic [iaid_pkg::DATA_W-1:0] next_i,
  output logic [iaid_pkg::DATA_W-1:0] word_o,
  output logic                        match_o
);

  localparam logic [CNT_W-1:0] MyIdx  = CNT_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] MyNext = CNT_W'(CELL_IDX + 1);

  logic [iaid_pkg::DATA_W-1:0] word_q, word_d;
  logic                        wr_en;

  always_comb begin
    wr_en  = 1'b0;
    word_d = word_q;
    if (ctrl_i.rep && (a_i == MyIdx)) begin
      wr_en  = 1'b1;
      word_d = value_i;
    end else if (ctrl_i.ins && (a_i == MyIdx)) begin
      wr_en  = 1'b1;
      word_d = value_i;
    end else if (ctrl_i.ins && (MyIdx > a_i) && (MyIdx <= count_i)) begin
      wr_en  = 1'b1;
      word_d = prev_i;
    end else if (ctrl_i.del && (MyIdx >= a_i) && (MyNext < count_i)) begin
      wr_en  = 1'b1;
      word_d = next_i;
    end else if (ctrl_i.swp && (a_i == MyIdx)) begin
      wr_en  = 1'b1;
      word_d = word_b_i;
    end else if (ctrl_i.swp && (b_i == MyIdx)) begin
      wr_en  = 1'b1;
      word_d = word_a_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      word_q <= word_d;
    end
  end

  assign word_o  = word_q;
  assign match_o = (word_q == value_i) && (MyIdx < count_i);

endmodule

### hw/rtl/indexed_array_insert_delete.sv
`timescale 1ns / 1ps
// Top level of the indexed array with insert and delete.
// Builds the row of iaid_cell instances and the count and result registers; uses iaid_pkg.
//
// Usage:
// Items enter on the s_axis channel: tuser carries the operation code and
// tdata carries the value, the index and the second index. Each item gives
// exactly one result on the m_axis channel with the status, the found flag,
// the read word and the number of entries in use after the operation.
// For every operation the row of cells shifts, writes, swaps or
// compares every entry at the clock edge that accepts the item, and the
// result appears in the output register on the following cycle. One item is
// accepted in every cycle while the receiver keeps taking results.
// When the receiver stalls, the result waits in the output register and a
// further item is accepted only in the cycle the waiting result is taken.
// Reset empties the array and the output register; cell contents are not
// cleared and are only read once written.
module indexed_array_insert_delete #(
  parameter int CAPACITY = iaid_pkg::CAPACITY_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // value [31:0], index, second_index, zero fill
  input  logic [((iaid_pkg::DATA_W + 2*$clog2(CAPACITY)) + 7)/8*8-1:0] s_axis_tdata,
  // func
  input  logic [iaid_pkg::FUNC_W-1:0]             s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // status [1:0], found [2], read_word [34:3], used_count, zero fill
  output logic [((iaid_pkg::STATUS_W + 1 + iaid_pkg::DATA_W + $clog2(CAPACITY + 1)) + 7)/8*8-1:0]
                                                  m_axis_tdata
);

  localparam int IW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int DW    = iaid_pkg::DATA_W;
  localparam int RES_W = iaid_pkg::STATUS_W + 1 + DW + CW;
  localparam int OUT_W = (RES_W + 7)/8*8;
  localparam logic [CW-1:0] Cap = CW'(CAPACITY);

  logic                 in_fire;
  iaid_pkg::op_e        op;
  logic [DW-1:0]        value;
  logic [CW-1:0]        a_ext, b_ext;
  logic [CW-1:0]        count_q, count_d;
  iaid_pkg::status_e    status;
  iaid_pkg::cell_ctrl_t ctrl;
  logic                 found;
  logic [DW-1:0]        rd_word;
  logic [DW-1:0]        word_a, word_b;
  logic [DW-1:0]        words [CAPACITY];
  logic [CAPACITY-1:0]  match;
  logic                 out_valid_q;
  logic [RES_W-1:0]     res_q;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign op            = iaid_pkg::op_e'(s_axis_tuser);
  assign value         = s_axis_tdata[DW-1:0];
  assign a_ext         = CW'(s_axis_tdata[DW +: IW]);
  assign b_ext         = CW'(s_axis_tdata[DW+IW +: IW]);

  always_comb begin
    word_a = '0;
    word_b = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      word_a = word_a | (words[i] & {DW{a_ext == CW'(i)}});
      word_b = word_b | (words[i] & {DW{b_ext == CW'(i)}});
    end
  end

  always_comb begin
    status  = iaid_pkg::ST_OK;
    ctrl    = '0;
    found   = 1'b0;
    rd_word = '0;
    count_d = count_q;
    unique case (op)
      iaid_pkg::OP_REPLACE: begin
        if (a_ext < count_q) ctrl.rep = in_fire;
        else status = iaid_pkg::ST_RANGE;
      end
      iaid_pkg::OP_INSERT: begin
        if (a_ext > count_q) begin
          status = iaid_pkg::ST_RANGE;
        end else if (count_q >= Cap) begin
          status = iaid_pkg::ST_FULL;
        end else begin
          ctrl.ins = in_fire;
          count_d  = count_q + CW'(1);
        end
      end
      iaid_pkg::OP_DELETE: begin
        if (a_ext < count_q) begin
          ctrl.del = in_fire;
          count_d  = count_q - CW'(1);
        end else begin
          status = iaid_pkg::ST_RANGE;
        end
      end
      iaid_pkg::OP_SWAP: begin
        if ((a_ext < count_q) && (b_ext < count_q)) ctrl.swp = in_fire;
        else status = iaid_pkg::ST_RANGE;
      end
      iaid_pkg::OP_FIND: begin
        found = |match;
      end
      iaid_pkg::OP_READ: begin
        if (a_ext < count_q) rd_word = word_a;
        else status = iaid_pkg::ST_RANGE;
      end
      default: begin
        status = iaid_pkg::ST_OK;
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DW-1:0] prev_w, next_w;
    if (g == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_prev
      assign prev_w = words[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_next
      assign next_w = words[g+1];
    end
    iaid_cell #(
      .CNT_W    (CW),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .a_i      (a_ext),
      .b_i      (b_ext),
      .count_i  (count_q),
      .value_i  (value),
      .word_a_i (word_a),
      .word_b_i (word_b),
      .prev_i   (prev_w),
      .next_i   (next_w),
      .word_o   (words[g]),
      .match_o  (match[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= {count_d, rd_word, found, status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(res_q);

  // The fill count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= Cap)
    else $error("entry count above capacity");

  // A full status is only given when the array is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (status == iaid_pkg::ST_FULL) |-> count_q == Cap)
    else $error("full status with free entries");

  // A successful insert grows the count by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && ctrl.ins |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not grow the count");

  // The reported count matches the count register after each item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> res_q[RES_W-1 -: CW] == count_q)
    else $error("reported count differs from count register");

endmodule
